>>> hw/rtl/mavg_pkg.sv
package mavg_pkg;

    localparam int WINDOW_DEPTH  = 16;
    localparam int PENDING_DEPTH = 8;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 8;
    localparam int CONF_W   = 4;
    localparam int WSIZE_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int WIN_AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WCNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCNT_W  = $clog2(PENDING_DEPTH + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_DEPTH + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_RATIO    = 2'd0,
        CFG_CONFIRM_COUNT = 2'd1,
        CFG_WINDOW_SIZE   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_FIRST     = 2'd0,
        ST_NORMAL    = 2'd1,
        ST_HELD      = 2'd2,
        ST_CONFIRMED = 2'd3
    } t_filt_status;

    typedef struct packed {
        logic         load_raw;
        logic         div_start;
        logic         mul;
        logic         append;
        logic         flush_push;
        logic         pend_clear;
        logic         push_raw;
        logic         drop;
        logic         out_load;
        t_filt_status kind;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic over_size;
        logic is_low;
        logic pend_reached;
        logic pend_left;
        logic div_busy;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> hw/rtl/mavg_dp.sv
module mavg_dp
    import mavg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SAMPLE_W-1:0]   i_raw,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [SAMPLE_W-1:0]   o_out_len,
    output logic [1:0]            o_out_status
);

    // Configuration registers
    logic [RATIO_W-1:0] r_ratio;
    logic [CONF_W-1:0]  r_confirm;
    logic [WSIZE_W-1:0] r_wsize;

    // Window ring and pending store
    logic [SAMPLE_W-1:0] r_win  [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_pend [PENDING_DEPTH];
    logic [WIN_AW-1:0]   r_head;
    logic [WCNT_W-1:0]   r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [PCNT_W-1:0]   r_pcount;
    logic [PCNT_W-1:0]   r_fidx;

    logic [SAMPLE_W-1:0] r_raw;
    logic [SAMPLE_W-1:0] r_thresh;

    // Restoring divider
    logic [SUM_W-1:0]     r_quo;
    logic [WCNT_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_busy;

    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_len;
    t_filt_status         r_out_kind;

    logic [WCNT_W-1:0]   eff_wsize;
    logic [PCNT_W-1:0]   eff_conf;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] push_val;
    logic                push_en;
    logic                win_full;
    logic [WCNT_W:0]     slot_sum;
    logic [WIN_AW-1:0]   slot;
    logic [WIN_AW-1:0]   head_inc;
    logic [SAMPLE_W-1:0] oldest;
    logic [WCNT_W:0]     trial;
    logic [WCNT_W:0]     trial_diff;
    logic                trial_ge;
    logic [SAMPLE_W+RATIO_W-1:0] product;

    always_comb begin
        if (r_wsize == '0) begin
            eff_wsize = WCNT_W'(1);
        end else if (32'(r_wsize) > WINDOW_DEPTH) begin
            eff_wsize = WCNT_W'(WINDOW_DEPTH);
        end else begin
            eff_wsize = WCNT_W'(r_wsize);
        end
        if (r_confirm == '0) begin
            eff_conf = PCNT_W'(1);
        end else if (32'(r_confirm) > PENDING_DEPTH) begin
            eff_conf = PCNT_W'(PENDING_DEPTH);
        end else begin
            eff_conf = PCNT_W'(r_confirm);
        end
    end

    assign mean     = r_quo[SAMPLE_W-1:0];
    assign push_en  = i_cmd.push_raw | i_cmd.flush_push;
    assign push_val = i_cmd.push_raw ? r_raw : r_pend[r_fidx[PEND_AW-1:0]];
    assign win_full = (32'(r_count) >= WINDOW_DEPTH);
    assign oldest   = r_win[r_head];
    assign head_inc = (32'(r_head) == WINDOW_DEPTH - 1) ? '0 : r_head + WIN_AW'(1);

    // With a full ring the oldest entry is overwritten in place.
    always_comb begin
        slot_sum = (WCNT_W+1)'(r_head) + (WCNT_W+1)'(r_count);
        if (win_full) begin
            slot = r_head;
        end else if (32'(slot_sum) >= WINDOW_DEPTH) begin
            slot = WIN_AW'(slot_sum - (WCNT_W+1)'(WINDOW_DEPTH));
        end else begin
            slot = WIN_AW'(slot_sum);
        end
    end

    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, r_count});
    assign trial_diff = trial - {1'b0, r_count};
    assign product    = r_quo[SAMPLE_W-1:0] * r_ratio;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_win[slot] <= push_val;
        end
        if (i_cmd.append && (32'(r_pcount) < PENDING_DEPTH)) begin
            r_pend[r_pcount[PEND_AW-1:0]] <= r_raw;
        end
        if (i_cmd.load_raw) begin
            r_raw <= i_raw;
        end
        if (i_cmd.mul) begin
            r_thresh <= product[SAMPLE_W+RATIO_W-1:RATIO_W];
        end
        if (i_cmd.div_start) begin
            r_quo <= r_sum;
            r_rem <= '0;
        end else if (r_div_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_diff[WCNT_W-1:0] : trial[WCNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.kind;
            if (i_cmd.kind == ST_FIRST || i_cmd.kind == ST_CONFIRMED) begin
                r_out_len <= r_raw;
            end else begin
                r_out_len <= mean;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= RATIO_W'(128);
            r_confirm   <= CONF_W'(3);
            r_wsize     <= WSIZE_W'(8);
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_pcount    <= '0;
            r_fidx      <= '0;
            r_div_cnt   <= '0;
            r_div_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DROP_RATIO: begin
                        r_ratio <= i_cfg_data[RATIO_W-1:0];
                    end
                    CFG_CONFIRM_COUNT: begin
                        r_confirm <= i_cfg_data[CONF_W-1:0];
                    end
                    CFG_WINDOW_SIZE: begin
                        r_wsize <= i_cfg_data[WSIZE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (push_en) begin
                if (win_full) begin
                    r_sum  <= r_sum - SUM_W'(oldest) + SUM_W'(push_val);
                    r_head <= head_inc;
                end else begin
                    r_sum   <= r_sum + SUM_W'(push_val);
                    r_count <= r_count + WCNT_W'(1);
                end
            end else if (i_cmd.drop) begin
                r_sum   <= r_sum - SUM_W'(oldest);
                r_head  <= head_inc;
                r_count <= r_count - WCNT_W'(1);
            end

            if (i_cmd.append && (32'(r_pcount) < PENDING_DEPTH)) begin
                r_pcount <= r_pcount + PCNT_W'(1);
            end else if (i_cmd.pend_clear) begin
                r_pcount <= '0;
            end

            if (i_cmd.flush_push) begin
                r_fidx <= r_fidx + PCNT_W'(1);
            end else if (i_cmd.pend_clear) begin
                r_fidx <= '0;
            end

            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DIV_CNT_W'(SUM_W);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(1)) begin
                    r_div_busy <= 1'b0;
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.over_size    = (r_count > eff_wsize);
    assign o_stat.is_low       = (r_raw < r_thresh);
    assign o_stat.pend_reached = (r_pcount >= eff_conf);
    assign o_stat.pend_left    = (r_fidx < r_pcount);
    assign o_stat.div_busy     = r_div_busy;
    assign o_stat.out_busy     = r_out_valid & ~i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_len    = r_out_len;
    assign o_out_status = r_out_kind;

endmodule

>>> hw/rtl/mavg_ctrl.sv
module mavg_ctrl
    import mavg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_MUL,
        S_CMP,
        S_APPEND,
        S_CONF,
        S_FLUSH,
        S_PUSH_RAW,
        S_TRIM,
        S_OUT
    } t_state;

    t_state       r_state, n_state;
    t_filt_status r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ST_FIRST;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_raw = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.count_zero) begin
                    n_kind  = ST_FIRST;
                    n_state = S_PUSH_RAW;
                end else begin
                    // The first division gives the mean that the sample is checked against.
                    n_kind = ST_HELD;
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = (r_kind == ST_NORMAL) ? S_OUT : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.is_low) begin
                    n_kind  = ST_HELD;
                    n_state = S_APPEND;
                end else begin
                    n_kind  = ST_NORMAL;
                    n_state = S_FLUSH;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = S_CONF;
            end
            S_CONF: begin
                if (i_stat.pend_reached) begin
                    n_kind  = ST_CONFIRMED;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FLUSH: begin
                if (i_stat.pend_left) begin
                    o_cmd.flush_push = 1'b1;
                end else begin
                    o_cmd.pend_clear = 1'b1;
                    n_state = (r_kind == ST_NORMAL) ? S_PUSH_RAW : S_TRIM;
                end
            end
            S_PUSH_RAW: begin
                o_cmd.push_raw = 1'b1;
                n_state = S_TRIM;
            end
            S_TRIM: begin
                if (i_stat.over_size) begin
                    o_cmd.drop = 1'b1;
                end else if (r_kind == ST_NORMAL) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/moving_average_drop_confirm.sv
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] raw_length
// m_axis    out        tdata[15:0] filtered_length, tuser[1:0] filter_status
// cfg       in         index[1:0] register, data[7:0] value (0 ratio, 1 confirm, 2 size)
//
// One word is in flight at a time. A first sample is stored and returned; a held
// drop runs the 21-step mean division, the threshold multiply, the compare and the
// pending append; a confirmed drop then flushes the pending entries and trims the
// window; a normal sample flushes, pushes, trims and divides a second time. The
// input is ready again the cycle after the result is loaded.
// Reset is synchronous and active low; the stores need no clearing pass.
// A stalled output holds its word while the next input is already being processed,
// and the next result waits until the output register is free.
module moving_average_drop_confirm
    import mavg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // [15:0] raw_length
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // [15:0] filtered_length
    output logic [1:0]            o_m_axis_tuser,   // [1:0] filter_status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = i_rst_n;

    mavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mavg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_raw        (i_s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_len    (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser)
    );

endmodule

>>> tb/testbench.sv
module testbench;
    import mavg_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int END_PAUSE       = 100;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 135;
    localparam int DIR_ROWS        = 28;

    typedef enum logic [1:0] {
        PACE_FULL       = 2'd0,
        PACE_SEND_IDLE  = 2'd1,
        PACE_RECV_STALL = 2'd2,
        PACE_BOTH       = 2'd3
    } t_pace;

    typedef enum logic [1:0] {
        ROW_CFG   = 2'd0,
        ROW_RAW   = 2'd1,
        ROW_TYPED = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [15:0]  len;
        t_filt_status kind;
    } t_filt_word;

    typedef struct packed {
        t_row_kind    kind;
        t_cfg_idx     reg_idx;
        logic [15:0]  value;
        logic [15:0]  exp_len;
        t_filt_status exp_kind;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [15:0]           o_m_axis_tdata;
    logic [1:0]            o_m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    moving_average_drop_confirm DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Filter state as the block should hold it.
    logic [15:0] win_buf [WINDOW_DEPTH];
    int unsigned win_cnt;
    int unsigned win_head;
    int unsigned win_sum;
    logic [15:0] pend_buf [PENDING_DEPTH];
    int unsigned pend_cnt;
    logic [7:0]  ratio_reg;
    logic [3:0]  confirm_reg;
    logic [4:0]  wsize_reg;

    t_filt_word filt_q [$];
    t_pace      pace = PACE_FULL;
    int         fail_count = 0;
    int         result_count = 0;
    int         kind_seen [4] = '{0, 0, 0, 0};
    int         cycle_count = 0;
    int         level = 30000;
    int         burst_left = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_TYPED, CFG_UNUSED,        16'd65535, 16'd65535, ST_FIRST},
        '{ROW_TYPED, CFG_UNUSED,        16'd65535, 16'd65535, ST_NORMAL},
        '{ROW_TYPED, CFG_UNUSED,        16'd0,     16'd65535, ST_HELD},
        '{ROW_TYPED, CFG_UNUSED,        16'd0,     16'd65535, ST_HELD},
        '{ROW_TYPED, CFG_UNUSED,        16'd0,     16'd0,     ST_CONFIRMED},
        '{ROW_CFG,   CFG_DROP_RATIO,    16'd0,     16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd0,     16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_DROP_RATIO,    16'd255,   16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_CONFIRM_COUNT, 16'd1,     16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd1,     16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_CONFIRM_COUNT, 16'd0,     16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd0,     16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_WINDOW_SIZE,   16'd31,    16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_CONFIRM_COUNT, 16'd15,    16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd40000, 16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd40000, 16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd100,   16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd100,   16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd100,   16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_CONFIRM_COUNT, 16'd2,     16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd100,   16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_WINDOW_SIZE,   16'd0,     16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd5000,  16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd5000,  16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_WINDOW_SIZE,   16'd16,    16'd0,     ST_FIRST},
        '{ROW_CFG,   CFG_UNUSED,        16'd255,   16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd65535, 16'd0,     ST_FIRST},
        '{ROW_RAW,   CFG_UNUSED,        16'd32768, 16'd0,     ST_FIRST}
    };

    function automatic void win_drop_oldest();
        if (win_cnt == 0) return;
        win_sum  -= win_buf[win_head];
        win_head  = (win_head + 1) % WINDOW_DEPTH;
        win_cnt--;
    endfunction

    function automatic void win_push(input logic [15:0] v);
        if (win_cnt >= WINDOW_DEPTH) win_drop_oldest();
        win_buf[(win_head + win_cnt) % WINDOW_DEPTH] = v;
        win_sum += v;
        win_cnt++;
    endfunction

    function automatic void win_trim();
        int unsigned lim;
        lim = wsize_reg;
        if (lim < 1) lim = 1;
        if (lim > WINDOW_DEPTH) lim = WINDOW_DEPTH;
        while (win_cnt > lim) win_drop_oldest();
    endfunction

    function automatic void pend_flush();
        for (int unsigned k = 0; k < pend_cnt; k++) win_push(pend_buf[k]);
        pend_cnt = 0;
    endfunction

    function automatic int unsigned win_mean();
        return (win_cnt == 0) ? 0 : win_sum / win_cnt;
    endfunction

    function automatic int unsigned low_limit();
        return (win_mean() * ratio_reg) >> 8;
    endfunction

    function automatic t_filt_word filter_predict(input logic [15:0] raw);
        t_filt_word  w;
        int unsigned need;
        need = confirm_reg;
        if (need < 1) need = 1;
        if (need > PENDING_DEPTH) need = PENDING_DEPTH;
        if (win_cnt == 0) begin
            win_push(raw);
            win_trim();
            w.len  = raw;
            w.kind = ST_FIRST;
        end else if (raw < low_limit()) begin
            if (pend_cnt < PENDING_DEPTH) begin
                pend_buf[pend_cnt] = raw;
                pend_cnt++;
            end
            if (pend_cnt >= need) begin
                pend_flush();
                win_trim();
                w.len  = raw;
                w.kind = ST_CONFIRMED;
            end else begin
                w.len  = 16'(win_mean());
                w.kind = ST_HELD;
            end
        end else begin
            pend_flush();
            win_push(raw);
            win_trim();
            w.len  = 16'(win_mean());
            w.kind = ST_NORMAL;
        end
        return w;
    endfunction

    function automatic void reg_update(input t_cfg_idx idx, input logic [7:0] data);
        case (idx)
            CFG_DROP_RATIO:    ratio_reg   = data;
            CFG_CONFIRM_COUNT: confirm_reg = data[3:0];
            CFG_WINDOW_SIZE:   wsize_reg   = data[4:0];
            default: ;
        endcase
    endfunction

    function automatic bit send_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        return (pace == PACE_SEND_IDLE && r < 48) || (pace == PACE_BOTH && r < 10);
    endfunction

    function automatic bit recv_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        return (pace == PACE_RECV_STALL && r < 48) || (pace == PACE_BOTH && r < 10);
    endfunction

    // Mostly samples around a drifting level, with bursts that fall below the
    // drop threshold so that holds and confirmations happen often.
    function automatic logic [15:0] next_raw();
        int unsigned thr;
        int unsigned r;
        int          spread;
        int          v;
        thr = low_limit();
        r   = $urandom_range(0, 99);
        if (burst_left == 0 && r < 14) burst_left = $urandom_range(1, 9);
        if (burst_left > 0) begin
            burst_left--;
            return (thr == 0) ? 16'd0 : 16'($urandom_range(0, thr - 1));
        end
        if (r >= 90) return 16'($urandom_range(0, 65535));
        if (r < 17) level = $urandom_range(0, 65535);
        spread = level / 16 + 1;
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    task automatic send_sample(input logic [15:0] raw, input bit typed,
                               input t_filt_word typed_word);
        t_filt_word w;
        i_cfg_valid <= 1'b0;
        while (send_pause()) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= raw;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        w = filter_predict(raw);
        filt_q.insert(filt_q.size(), typed ? typed_word : w);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        reg_update(idx, data);
    endtask

    // Drop both request lines and wait until every expected word is back.
    task automatic go_idle();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        do @(posedge i_clk); while (filt_q.size() != 0);
    endtask

    always @(posedge i_clk) begin : out_check
        t_filt_word want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (filt_q.size() == 0) begin
                $display("%0t: unexpected word, actual len %0d status %0d",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                fail_count++;
            end else begin
                want = filt_q[0];
                filt_q.delete(0);
                if (o_m_axis_tdata !== want.len || o_m_axis_tuser !== want.kind) begin
                    $display("%0t: mismatch, expected len %0d status %0d,",
                             $time, want.len, want.kind);
                    $display("    actual len %0d status %0d",
                             o_m_axis_tdata, o_m_axis_tuser);
                    fail_count++;
                end
                kind_seen[want.kind]++;
                result_count++;
            end
        end
        i_m_axis_tready <= !recv_stall();
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, filt_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_filt_word  typed_word;
        logic [7:0]  ratio_v;
        logic [7:0]  confirm_v;
        logic [7:0]  wsize_v;
        ratio_reg   = 8'd128;
        confirm_reg = 4'd3;
        wsize_reg   = 5'd8;
        win_cnt     = 0;
        win_head    = 0;
        win_sum     = 0;
        pend_cnt    = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            case (dir_rows[k].kind)
                ROW_CFG: begin
                    go_idle();
                    cfg_write(dir_rows[k].reg_idx, dir_rows[k].value[7:0]);
                end
                ROW_RAW: begin
                    send_sample(dir_rows[k].value, 1'b0, '0);
                end
                default: begin
                    typed_word.len  = dir_rows[k].exp_len;
                    typed_word.kind = dir_rows[k].exp_kind;
                    send_sample(dir_rows[k].value, 1'b1, typed_word);
                end
            endcase
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            go_idle();
            pace = t_pace'(ph % 4);
            case (ph)
                0: begin ratio_v = 8'd128; confirm_v = 8'd3;  wsize_v = 8'd8;  end
                1: begin ratio_v = 8'd255; confirm_v = 8'd1;  wsize_v = 8'd1;  end
                2: begin ratio_v = 8'd0;   confirm_v = 8'd8;  wsize_v = 8'd16; end
                3: begin ratio_v = 8'd200; confirm_v = 8'd15; wsize_v = 8'd31; end
                4: begin ratio_v = 8'd230; confirm_v = 8'd0;  wsize_v = 8'd0;  end
                default: begin
                    ratio_v   = 8'($urandom_range(0, 255));
                    confirm_v = 8'($urandom_range(0, 15));
                    wsize_v   = 8'($urandom_range(0, 31));
                end
            endcase
            cfg_write(CFG_DROP_RATIO, ratio_v);
            cfg_write(CFG_CONFIRM_COUNT, confirm_v);
            cfg_write(CFG_WINDOW_SIZE, wsize_v);
            if (ph == 6) cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
            for (int n = 0; n < WORDS_PER_PHASE; n++) send_sample(next_raw(), 1'b0, '0);
        end

        go_idle();
        repeat (END_PAUSE) @(posedge i_clk);
        fail_count += filt_q.size();

        $display("Checked %0d words: first %0d, normal %0d, held %0d, confirmed %0d.",
                 result_count, kind_seen[ST_FIRST], kind_seen[ST_NORMAL],
                 kind_seen[ST_HELD], kind_seen[ST_CONFIRMED]);
        $display("Ratio, confirm count and window size were swept across %0d settings.",
                 RANDOM_PHASES + 1);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_dp.sv
hw/rtl/mavg_ctrl.sv
hw/rtl/moving_average_drop_confirm.sv
tb/testbench.sv
